// ===== design/bfra_pkg.sv =====
// Package for the best-fit run allocator: payload structs, FSM states and
// controller/datapath command and status types. No dependencies.
package bfra_pkg;

	typedef struct packed {
		logic        kind;
		logic [23:0] length;
		logic [31:0] start_offset;
	} req_t;

	typedef struct packed {
		logic [31:0] offset;
		logic        from_end;
		logic        merged;
		logic [1:0]  error;
	} rsp_t;

	localparam logic       KIND_ALLOC = 1'b0;
	localparam logic [1:0] ERR_OK = 2'd0;
	localparam logic [1:0] ERR_FULL = 2'd1;
	localparam logic [1:0] ERR_OVERFLOW = 2'd2;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SCAN,
		ST_LAST,
		ST_DECIDE,
		ST_UPDATE,
		ST_RESP
	} state_t;

	typedef struct packed {
		logic load;
		logic scan_start;
		logic scan_step;
		logic decide;
		logic update;
	} cmd_t;

	typedef struct packed {
		logic scan_done;
	} status_t;

endpackage

// ===== design/best_fit_run_allocator_core.sv =====
// Best-fit run allocator, top level: controller plus datapath.
// Depends on bfra_pkg, bfra_ctrl and bfra_dp.
//
// Requests arrive on req (valid/ready); each gives one item on rsp.
// Allocate rounds length plus the header up to whole blocks and takes the
// smallest fitting run (lowest slot on ties), else grows the space end.
// Free rounds length up and merges with adjacent runs or adds a new run.
// One request at a time: the used slots are scanned one slot per cycle,
// then the last read drains, the request is decided and tables updated.
// A new request is taken the cycle after the result leaves.
// If the receiver stalls, the result holds and no new request is accepted.
// Reset empties the run table, sets block size log2 to 6 and space end to 0.
// Configuration writes (index 0 block size log2, 1 initial end, which also
// loads the space end) must be made while idle; the block does not check.
module best_fit_run_allocator_core #(
	parameter int RUN_SLOTS = 64,
	parameter int HEADER_BYTES = 8
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            req_valid,
	output logic            req_ready,
	input  bfra_pkg::req_t  req,
	output logic            rsp_valid,
	input  logic            rsp_ready,
	output bfra_pkg::rsp_t  rsp,
	input  logic            cfg_we,
	input  logic            cfg_index,
	input  logic [31:0]     cfg_wdata
);

	bfra_pkg::cmd_t    cmd;
	bfra_pkg::status_t status;

	bfra_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n),
		.in_valid(req_valid), .in_ready(req_ready),
		.out_valid(rsp_valid), .out_ready(rsp_ready),
		.status(status), .cmd(cmd)
	);

	bfra_dp #(.RUN_SLOTS(RUN_SLOTS), .HEADER_BYTES(HEADER_BYTES)) u_dp (
		.clk(clk), .arst_n(arst_n), .cmd(cmd), .status(status),
		.req(req), .rsp(rsp),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
	);

endmodule

// ===== design/bfra_ctrl.sv =====
// Controller FSM of the best-fit run allocator.
// Depends on bfra_pkg.
module bfra_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	output logic               out_valid,
	input  logic               out_ready,
	input  bfra_pkg::status_t  status,
	output bfra_pkg::cmd_t     cmd
);

	bfra_pkg::state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= bfra_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		cmd = '0;
		in_ready = 1'b0;
		out_valid = 1'b0;
		case (state_q)
			bfra_pkg::ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.load = 1'b1;
					cmd.scan_start = 1'b1;
					state_d = bfra_pkg::ST_SCAN;
				end
			end
			bfra_pkg::ST_SCAN: begin
				// Each cycle one slot is read from the memories until the scan is done.
				cmd.scan_step = 1'b1;
				if (status.scan_done) begin
					state_d = bfra_pkg::ST_LAST;
				end
			end
			bfra_pkg::ST_LAST: begin
				// Drains the last registered read into the comparators.
				cmd.scan_step = 1'b1;
				state_d = bfra_pkg::ST_DECIDE;
			end
			bfra_pkg::ST_DECIDE: begin
				cmd.decide = 1'b1;
				state_d = bfra_pkg::ST_UPDATE;
			end
			bfra_pkg::ST_UPDATE: begin
				cmd.update = 1'b1;
				state_d = bfra_pkg::ST_RESP;
			end
			bfra_pkg::ST_RESP: begin
				out_valid = 1'b1;
				if (out_ready) begin
					state_d = bfra_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = bfra_pkg::ST_IDLE;
			end
		endcase
	end

endmodule

// ===== design/bfra_dp.sv =====
// Datapath of the best-fit run allocator: run tables, scan comparators,
// slot recycling and space end. Depends on bfra_pkg.
module bfra_dp #(
	parameter int RUN_SLOTS = 64,
	parameter int HEADER_BYTES = 8
) (
	input  logic               clk,
	input  logic               arst_n,
	input  bfra_pkg::cmd_t     cmd,
	output bfra_pkg::status_t  status,
	input  bfra_pkg::req_t     req,
	output bfra_pkg::rsp_t     rsp,
	input  logic               cfg_we,
	input  logic               cfg_index,
	input  logic [31:0]        cfg_wdata
);

	localparam int SW = $clog2(RUN_SLOTS);
	localparam int CW = $clog2(RUN_SLOTS + 1);

	logic [31:0] start_mem [RUN_SLOTS];
	logic [31:0] len_mem [RUN_SLOTS];
	logic [SW-1:0] link_mem [RUN_SLOTS];
	logic [RUN_SLOTS-1:0] valid_q;

	// Link validity travels with the link entry.
	logic link_ok_mem [RUN_SLOTS];
	logic link_ok_q;

	logic [4:0]  bsl_q;
	logic [31:0] space_end_q;
	logic [CW-1:0] used_q;
	logic [SW-1:0] head_q;
	logic        head_ok_q;

	logic        kind_q;
	logic [32:0] amt_q;
	logic [31:0] soff_q;
	logic [32:0] stop_q;

	logic [CW-1:0] scan_q;
	logic [SW-1:0] rd_idx_s1;
	logic          rd_en_s1;
	logic [31:0]   rd_start_s1, rd_len_s1;

	logic          best_ok_q, bef_ok_q, aft_ok_q;
	logic [SW-1:0] best_q, bef_q, aft_q;
	logic [31:0]   best_len_q, best_start_q, bef_len_q, aft_len_q;
	logic [SW-1:0] link_rd_q;

	// Decision made in the decide state.
	logic [1:0]  err_q;
	logic        from_end_q, merged_q;
	logic [31:0] off_q;
	logic [33:0] total_q;

	logic [32:0] blk_m1, raw_amt;
	logic [33:0] tot_c;
	logic [32:0] end_sum;

	always_comb begin
		blk_m1 = (33'd1 << bsl_q) - 33'd1;
		if (req.kind == bfra_pkg::KIND_ALLOC) begin
			raw_amt = (33'(req.length) + 33'(HEADER_BYTES) + blk_m1) & ~blk_m1;
		end else begin
			raw_amt = (33'(req.length) + blk_m1) & ~blk_m1;
		end
		end_sum = 33'(space_end_q) + amt_q;
		tot_c = 34'(amt_q);
		if (bef_ok_q) tot_c = tot_c + 34'(bef_len_q);
		if (aft_ok_q) tot_c = tot_c + 34'(aft_len_q);
	end

	assign status.scan_done = (scan_q >= used_q) || (scan_q == CW'(RUN_SLOTS));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bsl_q <= 5'd6;
			space_end_q <= '0;
			used_q <= '0;
			head_q <= '1;
			head_ok_q <= 1'b0;
			valid_q <= '0;
			rd_en_s1 <= 1'b0;
		end else begin
			if (cfg_we) begin
				if (cfg_index == 1'b0) bsl_q <= cfg_wdata[4:0];
				else space_end_q <= cfg_wdata;
			end
			rd_en_s1 <= cmd.scan_step && !status.scan_done;
			if (cmd.update && err_q == bfra_pkg::ERR_OK) begin
				if (kind_q == bfra_pkg::KIND_ALLOC) begin
					if (from_end_q) space_end_q <= end_sum[31:0];
					else if (best_len_q == amt_q[31:0]) begin
						valid_q[best_q] <= 1'b0;
						head_q <= best_q;
						head_ok_q <= 1'b1;
					end
				end else if (bef_ok_q && aft_ok_q) begin
					valid_q[aft_q] <= 1'b0;
					head_q <= aft_q;
					head_ok_q <= 1'b1;
				end else if (!bef_ok_q && !aft_ok_q) begin
					if (head_ok_q) begin
						valid_q[head_q] <= 1'b1;
						head_q <= link_rd_q;
						head_ok_q <= link_ok_q;
					end else begin
						valid_q[used_q[SW-1:0]] <= 1'b1;
						used_q <= used_q + CW'(1);
					end
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			kind_q <= req.kind;
			amt_q <= raw_amt;
			soff_q <= req.start_offset;
			stop_q <= 33'(req.start_offset) + raw_amt;
			best_ok_q <= 1'b0;
			bef_ok_q <= 1'b0;
			aft_ok_q <= 1'b0;
		end
		if (cmd.scan_start) begin
			scan_q <= '0;
		end
		if (cmd.scan_step && !status.scan_done) begin
			rd_start_s1 <= start_mem[scan_q[SW-1:0]];
			rd_len_s1 <= len_mem[scan_q[SW-1:0]];
			rd_idx_s1 <= scan_q[SW-1:0];
			scan_q <= scan_q + CW'(1);
		end
		link_rd_q <= link_mem[head_q];
		link_ok_q <= link_ok_mem[head_q];
		if (rd_en_s1 && valid_q[rd_idx_s1]) begin
			if (kind_q == bfra_pkg::KIND_ALLOC) begin
				if (33'(rd_len_s1) >= amt_q && (!best_ok_q || rd_len_s1 < best_len_q)) begin
					best_ok_q <= 1'b1;
					best_q <= rd_idx_s1;
					best_len_q <= rd_len_s1;
					best_start_q <= rd_start_s1;
				end
			end else if (stop_q == 33'(rd_start_s1)) begin
				aft_ok_q <= 1'b1;
				aft_q <= rd_idx_s1;
				aft_len_q <= rd_len_s1;
			end else if (33'(soff_q) == 33'(rd_start_s1) + 33'(rd_len_s1)) begin
				bef_ok_q <= 1'b1;
				bef_q <= rd_idx_s1;
				bef_len_q <= rd_len_s1;
			end
		end
		if (cmd.decide) begin
			err_q <= bfra_pkg::ERR_OK;
			from_end_q <= 1'b0;
			merged_q <= 1'b0;
			total_q <= tot_c;
			if (kind_q == bfra_pkg::KIND_ALLOC) begin
				off_q <= best_start_q;
				if (!best_ok_q) begin
					if (end_sum[32]) begin
						err_q <= bfra_pkg::ERR_OVERFLOW;
						off_q <= '0;
					end else begin
						from_end_q <= 1'b1;
						off_q <= space_end_q;
					end
				end
			end else begin
				off_q <= soff_q;
				if (tot_c[33:32] != 2'b00) err_q <= bfra_pkg::ERR_OVERFLOW;
				else if (bef_ok_q || aft_ok_q) merged_q <= 1'b1;
				else if (!head_ok_q && used_q == CW'(RUN_SLOTS)) err_q <= bfra_pkg::ERR_FULL;
			end
		end
		if (cmd.update && err_q == bfra_pkg::ERR_OK) begin
			if (kind_q == bfra_pkg::KIND_ALLOC) begin
				if (!from_end_q && best_len_q != amt_q[31:0]) begin
					start_mem[best_q] <= best_start_q + amt_q[31:0];
					len_mem[best_q] <= best_len_q - amt_q[31:0];
				end else if (!from_end_q) begin
					link_mem[best_q] <= head_q;
					link_ok_mem[best_q] <= head_ok_q;
				end
			end else if (bef_ok_q) begin
				len_mem[bef_q] <= total_q[31:0];
				if (aft_ok_q) begin
					link_mem[aft_q] <= head_q;
					link_ok_mem[aft_q] <= head_ok_q;
				end
			end else if (aft_ok_q) begin
				start_mem[aft_q] <= soff_q;
				len_mem[aft_q] <= total_q[31:0];
			end else if (head_ok_q) begin
				start_mem[head_q] <= soff_q;
				len_mem[head_q] <= total_q[31:0];
			end else begin
				start_mem[used_q[SW-1:0]] <= soff_q;
				len_mem[used_q[SW-1:0]] <= total_q[31:0];
			end
		end
	end

	assign rsp.offset = off_q;
	assign rsp.from_end = from_end_q;
	assign rsp.merged = merged_q;
	assign rsp.error = err_q;

	a_used_bound: assert property (@(posedge clk) disable iff (!arst_n)
		used_q <= CW'(RUN_SLOTS)) else $error("slot count above table size");
	a_scan_bound: assert property (@(posedge clk) disable iff (!arst_n)
		scan_q <= CW'(RUN_SLOTS)) else $error("scan index past table");
	a_used_step: assert property (@(posedge clk) disable iff (!arst_n)
		!cmd.update |=> (used_q == $past(used_q))) else $error("slot count moved outside update");

endmodule
